/* hw/rtl/csd_pkg.sv */
// Shared types, widths and constants for the degree sine/cosine pipeline.
// Holds the arctangent table (degrees, 20 fractional bits) and the gain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

    // Defaults for the top-level parameters
    localparam int ITERATIONS_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    localparam int ANGLE_W   = 32;  // input angle width
    localparam int IFRAC     = 20;  // internal fractional bits
    localparam int TABLE_LEN = 24;  // arctangent table entries
    localparam int IDX_W     = 5;   // table index width
    localparam int ANG_W     = 29;  // internal angle width, holds 360 deg in Q20
    localparam int XY_W      = 23;  // vector component width, signed
    localparam int GAIN_W    = 21;  // inverse gain width, signed
    localparam int PROD_W    = XY_W + GAIN_W;
    localparam int ROUND_SH  = 2 * IFRAC - 16;
    localparam int MAG_W     = 17;  // magnitude of a Q1.16 unit value
    localparam int RAW_W     = 18;
    localparam int HUN_W     = 8;
    localparam int HUN_PW    = MAG_W + 7;

    localparam logic signed [GAIN_W-1:0] GAIN_Q20  = GAIN_W'(636751);
    localparam logic [MAG_W-1:0]         ONE_Q16   = MAG_W'(65536);
    localparam logic [PROD_W-1:0]        ROUND_HALF = PROD_W'(1) << (ROUND_SH - 1);
    localparam logic [6:0]               HUN_SCALE = 7'd100;
    localparam logic [HUN_PW-1:0]        HUN_HALF  = HUN_PW'(32768);

    localparam logic [ANG_W-1:0] DEG90_Q20  = ANG_W'(90)  << IFRAC;
    localparam logic [ANG_W-1:0] DEG180_Q20 = ANG_W'(180) << IFRAC;
    localparam logic [ANG_W-1:0] DEG270_Q20 = ANG_W'(270) << IFRAC;
    localparam logic [ANG_W-1:0] DEG360_Q20 = ANG_W'(360) << IFRAC;

    typedef struct packed {
        logic neg_sin;
        logic neg_cos;
    } quad_flags_t;

    // atan(2^-i) in degrees, Q20
    function automatic logic [ANG_W-1:0] atan_q20(input logic [IDX_W-1:0] idx);
        logic [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = ANG_W'(47185920);
            5'd1:    val = ANG_W'(27855475);
            5'd2:    val = ANG_W'(14718068);
            5'd3:    val = ANG_W'(7471121);
            5'd4:    val = ANG_W'(3750058);
            5'd5:    val = ANG_W'(1876857);
            5'd6:    val = ANG_W'(938658);
            5'd7:    val = ANG_W'(469357);
            5'd8:    val = ANG_W'(234682);
            5'd9:    val = ANG_W'(117342);
            5'd10:   val = ANG_W'(58671);
            5'd11:   val = ANG_W'(29335);
            5'd12:   val = ANG_W'(14668);
            5'd13:   val = ANG_W'(7334);
            5'd14:   val = ANG_W'(3667);
            5'd15:   val = ANG_W'(1833);
            5'd16:   val = ANG_W'(917);
            5'd17:   val = ANG_W'(458);
            5'd18:   val = ANG_W'(229);
            5'd19:   val = ANG_W'(115);
            5'd20:   val = ANG_W'(57);
            5'd21:   val = ANG_W'(29);
            5'd22:   val = ANG_W'(14);
            5'd23:   val = ANG_W'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/csd_mod_cell.sv */
// One step of the modulo-360 reduction: conditional subtract of a fixed
// multiple of the period, with a valid/ready register stage.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csd_mod_cell #(
    parameter int            U_W = 33,
    parameter logic [U_W-1:0] SUB = '0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [U_W-1:0] in_u,
    output logic                in_ready,
    output logic                out_valid,
    output logic [U_W-1:0]      out_u,
    input  wire logic           out_ready
);

    logic           valid_reg;
    logic           valid_next;
    logic [U_W-1:0] u_reg;
    logic [U_W-1:0] u_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign u_next     = (in_u >= SUB) ? in_u - SUB : in_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            u_reg <= u_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_u     = u_reg;

endmodule

`default_nettype wire

/* hw/rtl/csd_rot_cell.sv */
// One CORDIC rotation stage in degrees: shift-add on x/y, angle update
// from the arctangent table. Depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csd_rot_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [csd_pkg::XY_W-1:0]   in_x,
    input  wire logic signed [csd_pkg::XY_W-1:0]   in_y,
    input  wire logic signed [csd_pkg::ANG_W-1:0]  in_z,
    input  wire csd_pkg::quad_flags_t              in_flags,
    output logic                                   in_ready,
    output logic                                   out_valid,
    output logic signed [csd_pkg::XY_W-1:0]        out_x,
    output logic signed [csd_pkg::XY_W-1:0]        out_y,
    output logic signed [csd_pkg::ANG_W-1:0]       out_z,
    output csd_pkg::quad_flags_t                   out_flags,
    input  wire logic                              out_ready
);

    localparam logic signed [csd_pkg::ANG_W-1:0] ATAN =
        csd_pkg::atan_q20(csd_pkg::IDX_W'(STAGE));

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [csd_pkg::XY_W-1:0]    x_reg;
    logic signed [csd_pkg::XY_W-1:0]    x_next;
    logic signed [csd_pkg::XY_W-1:0]    y_reg;
    logic signed [csd_pkg::XY_W-1:0]    y_next;
    logic signed [csd_pkg::ANG_W-1:0]   z_reg;
    logic signed [csd_pkg::ANG_W-1:0]   z_next;
    csd_pkg::quad_flags_t               flags_reg;
    logic signed [csd_pkg::XY_W-1:0]    dx;
    logic signed [csd_pkg::XY_W-1:0]    dy;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // floor shifts
    assign dx = in_y >>> STAGE;
    assign dy = in_x >>> STAGE;

    always_comb
    begin
        if (!in_z[csd_pkg::ANG_W-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_flags = flags_reg;

endmodule

`default_nettype wire

/* hw/rtl/csd_scale_unit.sv */
// Gain scaling, rounding, quadrant sign fix, saturation and the
// hundredths conversion, three register stages. Depends on csd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csd_scale_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic signed [csd_pkg::XY_W-1:0]  in_x,
    input  wire logic signed [csd_pkg::XY_W-1:0]  in_y,
    input  wire csd_pkg::quad_flags_t             in_flags,
    output logic                                  in_ready,
    output logic                                  out_valid,
    output logic signed [csd_pkg::RAW_W-1:0]      sine_raw,
    output logic signed [csd_pkg::RAW_W-1:0]      cosine_raw,
    output logic signed [csd_pkg::HUN_W-1:0]      sine_hundredths,
    output logic signed [csd_pkg::HUN_W-1:0]      cosine_hundredths,
    input  wire logic                             out_ready
);

    // rounded magnitude, half away from zero, clamped to 1.0
    function automatic logic [csd_pkg::MAG_W-1:0] round_clamp(
        input logic signed [csd_pkg::PROD_W-1:0] p
    );
        logic [csd_pkg::PROD_W-1:0] m;
        logic [csd_pkg::PROD_W-1:0] r;
        m = p[csd_pkg::PROD_W-1] ? csd_pkg::PROD_W'(-p) : csd_pkg::PROD_W'(p);
        r = (m + csd_pkg::ROUND_HALF) >> csd_pkg::ROUND_SH;
        return (r > csd_pkg::PROD_W'(csd_pkg::ONE_Q16)) ? csd_pkg::ONE_Q16
                                                         : csd_pkg::MAG_W'(r);
    endfunction

    function automatic logic [csd_pkg::HUN_W-1:0] to_hundredths(
        input logic [csd_pkg::MAG_W-1:0] mag
    );
        logic [csd_pkg::HUN_PW-1:0] prod;
        prod = csd_pkg::HUN_PW'(mag) * csd_pkg::HUN_PW'(csd_pkg::HUN_SCALE);
        return csd_pkg::HUN_W'((prod + csd_pkg::HUN_HALF) >> 16);
    endfunction

    // stage A: multiply by inverse gain
    logic                                a_valid_reg;
    logic                                a_valid_next;
    logic signed [csd_pkg::PROD_W-1:0]   a_px_reg;
    logic signed [csd_pkg::PROD_W-1:0]   a_px_next;
    logic signed [csd_pkg::PROD_W-1:0]   a_py_reg;
    logic signed [csd_pkg::PROD_W-1:0]   a_py_next;
    csd_pkg::quad_flags_t                a_flags_reg;
    logic                                a_ready;

    // stage B: round, clamp, resolve sign
    logic                                b_valid_reg;
    logic                                b_valid_next;
    logic [csd_pkg::MAG_W-1:0]           b_mag_s_reg;
    logic [csd_pkg::MAG_W-1:0]           b_mag_s_next;
    logic [csd_pkg::MAG_W-1:0]           b_mag_c_reg;
    logic [csd_pkg::MAG_W-1:0]           b_mag_c_next;
    logic                                b_neg_s_reg;
    logic                                b_neg_s_next;
    logic                                b_neg_c_reg;
    logic                                b_neg_c_next;
    logic                                b_ready;

    // stage C: output register
    logic                                c_valid_reg;
    logic                                c_valid_next;
    logic signed [csd_pkg::RAW_W-1:0]    c_sin_reg;
    logic signed [csd_pkg::RAW_W-1:0]    c_sin_next;
    logic signed [csd_pkg::RAW_W-1:0]    c_cos_reg;
    logic signed [csd_pkg::RAW_W-1:0]    c_cos_next;
    logic signed [csd_pkg::HUN_W-1:0]    c_sin_h_reg;
    logic signed [csd_pkg::HUN_W-1:0]    c_sin_h_next;
    logic signed [csd_pkg::HUN_W-1:0]    c_cos_h_reg;
    logic signed [csd_pkg::HUN_W-1:0]    c_cos_h_next;
    logic                                c_ready;
    logic [csd_pkg::HUN_W-1:0]           h_s;
    logic [csd_pkg::HUN_W-1:0]           h_c;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid    : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    assign a_px_next = csd_pkg::PROD_W'(in_x) * csd_pkg::PROD_W'(csd_pkg::GAIN_Q20);
    assign a_py_next = csd_pkg::PROD_W'(in_y) * csd_pkg::PROD_W'(csd_pkg::GAIN_Q20);

    // negating before the clamp equals clamping before negating
    assign b_mag_s_next = round_clamp(a_py_reg);
    assign b_mag_c_next = round_clamp(a_px_reg);
    assign b_neg_s_next = a_py_reg[csd_pkg::PROD_W-1] ^ a_flags_reg.neg_sin;
    assign b_neg_c_next = a_px_reg[csd_pkg::PROD_W-1] ^ a_flags_reg.neg_cos;

    assign h_s = to_hundredths(b_mag_s_reg);
    assign h_c = to_hundredths(b_mag_c_reg);

    assign c_sin_next   = b_neg_s_reg ? -csd_pkg::RAW_W'(b_mag_s_reg)
                                      :  csd_pkg::RAW_W'(b_mag_s_reg);
    assign c_cos_next   = b_neg_c_reg ? -csd_pkg::RAW_W'(b_mag_c_reg)
                                      :  csd_pkg::RAW_W'(b_mag_c_reg);
    assign c_sin_h_next = b_neg_s_reg ? -h_s : h_s;
    assign c_cos_h_next = b_neg_c_reg ? -h_c : h_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_px_reg    <= a_px_next;
            a_py_reg    <= a_py_next;
            a_flags_reg <= in_flags;
        end
        if (b_ready)
        begin
            b_mag_s_reg <= b_mag_s_next;
            b_mag_c_reg <= b_mag_c_next;
            b_neg_s_reg <= b_neg_s_next;
            b_neg_c_reg <= b_neg_c_next;
        end
        if (c_ready)
        begin
            c_sin_reg   <= c_sin_next;
            c_cos_reg   <= c_cos_next;
            c_sin_h_reg <= c_sin_h_next;
            c_cos_h_reg <= c_cos_h_next;
        end
    end

    assign out_valid         = c_valid_reg;
    assign sine_raw          = c_sin_reg;
    assign cosine_raw        = c_cos_reg;
    assign sine_hundredths   = c_sin_h_reg;
    assign cosine_hundredths = c_cos_h_reg;

endmodule

`default_nettype wire

/* hw/rtl/cordic_sine_cosine_degrees.sv */
// Top level: degree sine/cosine by CORDIC rotation, fully pipelined.
// Depends on csd_pkg, csd_mod_cell, csd_rot_cell, csd_scale_unit.
//
//   channel   handshake               payload
//   angle     angle_valid/angle_stall angle_deg (s32, Q15.16)
//   result    result_valid/result_stall sine_raw, cosine_raw (s18, Q1.16),
//                                     sine_hundredths, cosine_hundredths (s8)
//
// One request per cycle while angle_stall is low. The stages are the input register,
// one compare-subtract cell per power-of-two period multiple, the fold stage,
// one cell per rotation and three scale stages.
// Every stage holds its own valid bit, so bubbles collapse under a stall;
// angle_stall rises only when every stage up to the output is full.
// Reset clears all valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cordic_sine_cosine_degrees #(
    parameter int ITERATIONS      = csd_pkg::ITERATIONS_DEF,
    parameter int ANGLE_FRAC_BITS = csd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                angle_valid,
    output logic                                     angle_stall,
    input  wire logic signed [csd_pkg::ANGLE_W-1:0]  angle_deg,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [csd_pkg::RAW_W-1:0]         sine_raw,
    output logic signed [csd_pkg::RAW_W-1:0]         cosine_raw,
    output logic signed [csd_pkg::HUN_W-1:0]         sine_hundredths,
    output logic signed [csd_pkg::HUN_W-1:0]         cosine_hundredths
);

    localparam longint unsigned PERIOD = 64'd360 << ANGLE_FRAC_BITS;
    // smallest period multiple that makes any input angle non-negative
    localparam longint unsigned OFFSET =
        ((64'd1 << 31) + PERIOD - 64'd1) / PERIOD * PERIOD;
    localparam longint unsigned U_MAX = OFFSET + (64'd1 << 31) - 64'd1;
    localparam int U_W        = $clog2(U_MAX + 64'd1);
    localparam int MOD_STEPS  = $clog2(U_MAX / PERIOD + 64'd1);
    localparam int ROT_STAGES = (ITERATIONS < csd_pkg::TABLE_LEN) ? ITERATIONS
                                                                  : csd_pkg::TABLE_LEN;

    // input register
    logic           in_valid_reg;
    logic           in_valid_next;
    logic [U_W-1:0] in_u_reg;
    logic [U_W-1:0] in_u_next;
    logic           in_ready;

    logic           mod_v   [MOD_STEPS+1];
    logic           mod_rdy [MOD_STEPS+1];
    logic [U_W-1:0] mod_u   [MOD_STEPS+1];

    // fold stage
    logic                               fold_valid_reg;
    logic                               fold_valid_next;
    logic signed [csd_pkg::ANG_W-1:0]   fold_z_reg;
    logic signed [csd_pkg::ANG_W-1:0]   fold_z_next;
    csd_pkg::quad_flags_t               fold_flags_reg;
    csd_pkg::quad_flags_t               fold_flags_next;
    logic                               fold_ready;
    logic [csd_pkg::ANG_W-1:0]          r20;

    logic                               rot_v     [ROT_STAGES+1];
    logic                               rot_rdy   [ROT_STAGES+1];
    logic signed [csd_pkg::XY_W-1:0]    rot_x     [ROT_STAGES+1];
    logic signed [csd_pkg::XY_W-1:0]    rot_y     [ROT_STAGES+1];
    logic signed [csd_pkg::ANG_W-1:0]   rot_z     [ROT_STAGES+1];
    csd_pkg::quad_flags_t               rot_flags [ROT_STAGES+1];

    // ---------------- input register ----------------
    assign in_ready      = !in_valid_reg || mod_rdy[0];
    assign angle_stall   = !in_ready;
    assign in_valid_next = in_ready ? angle_valid : in_valid_reg;
    assign in_u_next     = U_W'(angle_deg) + U_W'(OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            fold_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            fold_valid_reg <= fold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            in_u_reg <= in_u_next;
        end
        if (fold_ready)
        begin
            fold_z_reg     <= fold_z_next;
            fold_flags_reg <= fold_flags_next;
        end
    end

    assign mod_v[0] = in_valid_reg;
    assign mod_u[0] = in_u_reg;

    // ---------------- modulo reduction chain ----------------
    for (genvar k = 0; k < MOD_STEPS; k++)
    begin : g_mod
        localparam longint unsigned SUB_K = PERIOD << (MOD_STEPS - 1 - k);

        csd_mod_cell #(
            .U_W (U_W),
            .SUB (U_W'(SUB_K))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (mod_v[k]),
            .in_u      (mod_u[k]),
            .in_ready  (mod_rdy[k]),
            .out_valid (mod_v[k+1]),
            .out_u     (mod_u[k+1]),
            .out_ready (mod_rdy[k+1])
        );
    end

    // ---------------- fold into first quadrant ----------------
    assign mod_rdy[MOD_STEPS] = fold_ready;
    assign fold_ready         = !fold_valid_reg || rot_rdy[0];
    assign fold_valid_next    = fold_ready ? mod_v[MOD_STEPS] : fold_valid_reg;

    if (ANGLE_FRAC_BITS <= csd_pkg::IFRAC)
    begin : g_widen
        assign r20 = csd_pkg::ANG_W'(mod_u[MOD_STEPS])
                     << (csd_pkg::IFRAC - ANGLE_FRAC_BITS);
    end
    else
    begin : g_narrow
        // drop fraction bits below Q20 (floor)
        assign r20 = csd_pkg::ANG_W'(mod_u[MOD_STEPS]
                     >> (ANGLE_FRAC_BITS - csd_pkg::IFRAC));
    end

    always_comb
    begin
        fold_flags_next = '0;
        if (r20 > csd_pkg::DEG270_Q20)
        begin
            fold_z_next             = csd_pkg::DEG360_Q20 - r20;
            fold_flags_next.neg_sin = 1'b1;
        end
        else if (r20 > csd_pkg::DEG180_Q20)
        begin
            fold_z_next             = r20 - csd_pkg::DEG180_Q20;
            fold_flags_next.neg_sin = 1'b1;
            fold_flags_next.neg_cos = 1'b1;
        end
        else if (r20 > csd_pkg::DEG90_Q20)
        begin
            fold_z_next             = csd_pkg::DEG180_Q20 - r20;
            fold_flags_next.neg_cos = 1'b1;
        end
        else
        begin
            fold_z_next = r20;
        end
    end

    assign rot_v[0]     = fold_valid_reg;
    assign rot_x[0]     = csd_pkg::XY_W'(1) << csd_pkg::IFRAC;
    assign rot_y[0]     = '0;
    assign rot_z[0]     = fold_z_reg;
    assign rot_flags[0] = fold_flags_reg;

    // ---------------- rotation chain ----------------
    for (genvar i = 0; i < ROT_STAGES; i++)
    begin : g_rot
        csd_rot_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_v[i]),
            .in_x      (rot_x[i]),
            .in_y      (rot_y[i]),
            .in_z      (rot_z[i]),
            .in_flags  (rot_flags[i]),
            .in_ready  (rot_rdy[i]),
            .out_valid (rot_v[i+1]),
            .out_x     (rot_x[i+1]),
            .out_y     (rot_y[i+1]),
            .out_z     (rot_z[i+1]),
            .out_flags (rot_flags[i+1]),
            .out_ready (rot_rdy[i+1])
        );
    end

    // ---------------- scaling and output ----------------
    csd_scale_unit u_scale (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (rot_v[ROT_STAGES]),
        .in_x              (rot_x[ROT_STAGES]),
        .in_y              (rot_y[ROT_STAGES]),
        .in_flags          (rot_flags[ROT_STAGES]),
        .in_ready          (rot_rdy[ROT_STAGES]),
        .out_valid         (result_valid),
        .sine_raw          (sine_raw),
        .cosine_raw        (cosine_raw),
        .sine_hundredths   (sine_hundredths),
        .cosine_hundredths (cosine_hundredths),
        .out_ready         (!result_stall)
    );

    // ---------------- assertions ----------------
    // input backs up only when the whole chain is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> (result_valid && result_stall))
        else $error("angle_stall without a held result");

    // folded angle always lands in [0, 90] degrees
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        fold_valid_reg |-> (!fold_z_reg[csd_pkg::ANG_W-1]
                            && fold_z_reg <= $signed(csd_pkg::DEG90_Q20)))
        else $error("folded angle out of first quadrant");

    a_sin_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (sine_raw <= 18'sd65536 && sine_raw >= -18'sd65536
                          && cosine_raw <= 18'sd65536 && cosine_raw >= -18'sd65536))
        else $error("raw output beyond unit range");

    // hundredths are never negative while the raw value is non-negative
    a_hun_sign: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((sine_raw[csd_pkg::RAW_W-1] || !sine_hundredths[csd_pkg::HUN_W-1])
                          && (cosine_raw[csd_pkg::RAW_W-1]
                              || !cosine_hundredths[csd_pkg::HUN_W-1])))
        else $error("hundredths sign mismatch");

endmodule

`default_nettype wire

/* sim/cordic_sine_cosine_degrees_tb.sv */
// Self-checking bench for cordic_sine_cosine_degrees: directed and random angles,
// each result checked against an in-bench fixed-point sine/cosine calculation.
// Depends on csd_pkg and the cordic_sine_cosine_degrees top level.
`timescale 1ns / 1ps

module cordic_sine_cosine_degrees_tb;

    localparam int ANGLE_W = csd_pkg::ANGLE_W;
    localparam int RAW_W   = csd_pkg::RAW_W;
    localparam int HUN_W   = csd_pkg::HUN_W;

    localparam int ROT_STAGES  = 16;
    localparam int ANGLE_FRAC  = 16;
    localparam int INT_FRAC    = 20;
    localparam int SHIFT_UP    = INT_FRAC - ANGLE_FRAC;
    localparam int ATAN_LEN    = 24;
    localparam longint GAIN    = 636751;
    localparam longint UNIT    = 65536;
    localparam int SCALE_SH    = 2 * INT_FRAC - 16;
    localparam longint PERIOD  = longint'(360) <<< ANGLE_FRAC;
    localparam longint FULL    = longint'(360) <<< INT_FRAC;
    localparam longint DEG270  = longint'(270) <<< INT_FRAC;
    localparam longint DEG180  = longint'(180) <<< INT_FRAC;
    localparam longint DEG90   = longint'(90) <<< INT_FRAC;

    localparam int RANDOM_ANGLES = 750;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT    = 5000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT       = 350;

    // atan(2^-i) in degrees, 20 fractional bits
    localparam longint ATAN_DEG[ATAN_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    localparam int DIRECTED[24] = '{
        0, 1, -1,
        90 * 65536, 90 * 65536 + 1, 89 * 65536 + 65535,
        180 * 65536, 180 * 65536 + 1, 270 * 65536, 270 * 65536 + 1,
        360 * 65536, 360 * 65536 - 1, 45 * 65536, 30 * 65536, 60 * 65536,
        135 * 65536, 225 * 65536, 315 * 65536, -90 * 65536, -180 * 65536,
        -1 * 65536, 810 * 65536, 32'h7FFF_FFFF, 32'h8000_0000
    };

    typedef struct {
        logic signed [RAW_W-1:0] sine_raw;
        logic signed [RAW_W-1:0] cosine_raw;
        logic signed [HUN_W-1:0] sine_hundredths;
        logic signed [HUN_W-1:0] cosine_hundredths;
    } trig_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        bit                        wait_empty;
    } angle_req_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      angle_valid = 1'b0;
    logic                      angle_stall;
    logic signed [ANGLE_W-1:0] angle_deg = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [RAW_W-1:0]   sine_raw;
    logic signed [RAW_W-1:0]   cosine_raw;
    logic signed [HUN_W-1:0]   sine_hundredths;
    logic signed [HUN_W-1:0]   cosine_hundredths;

    angle_req_t  angle_reqs[$];
    trig_t       trig_pending[$];
    int          accepted_cnt = 0;
    int          checked_cnt = 0;
    int          errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          mode_left = 0;
    int          pattern_cnt = 0;
    int          idle_cycles = 0;
    stall_mode_t stall_mode = STALL_NONE;

    cordic_sine_cosine_degrees #(
        .ITERATIONS     (ROT_STAGES),
        .ANGLE_FRAC_BITS(ANGLE_FRAC)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .angle_valid      (angle_valid),
        .angle_stall      (angle_stall),
        .angle_deg        (angle_deg),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .sine_raw         (sine_raw),
        .cosine_raw       (cosine_raw),
        .sine_hundredths  (sine_hundredths),
        .cosine_hundredths(cosine_hundredths)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gain product back to Q16, rounded half away from zero
    function automatic longint scale_to_q16(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint saturate_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    function automatic longint to_percent(input longint raw);
        longint mag;
        mag = (raw < 0) ? -raw : raw;
        mag = (mag * 100 + UNIT / 2) >>> 16;
        return (raw < 0) ? -mag : mag;
    endfunction

    function automatic trig_t sincos_of_angle(input logic signed [ANGLE_W-1:0] ang);
        longint red;
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint sv;
        longint cv;
        bit     flip_s;
        bit     flip_c;
        trig_t  res;
        flip_s = 0;
        flip_c = 0;
        red = longint'(ang) % PERIOD;
        if (red < 0)
            red = red + PERIOD;
        if (SHIFT_UP >= 0)
            red = red <<< SHIFT_UP;
        else
            red = red >>> (-SHIFT_UP);
        // fold into the first quadrant; boundaries themselves go to the lower range
        if (red > DEG270)
        begin
            z = FULL - red;
            flip_s = 1;
        end
        else if (red > DEG180)
        begin
            z = red - DEG180;
            flip_s = 1;
            flip_c = 1;
        end
        else if (red > DEG90)
        begin
            z = DEG180 - red;
            flip_c = 1;
        end
        else
            z = red;
        x = longint'(1) <<< INT_FRAC;
        y = 0;
        for (int i = 0; i < ROT_STAGES && i < ATAN_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_DEG[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_DEG[i];
            end
        end
        sv = scale_to_q16(y * GAIN);
        cv = scale_to_q16(x * GAIN);
        if (flip_s)
            sv = -sv;
        if (flip_c)
            cv = -cv;
        sv = saturate_unit(sv);
        cv = saturate_unit(cv);
        res.sine_raw          = RAW_W'(sv);
        res.cosine_raw        = RAW_W'(cv);
        res.sine_hundredths   = HUN_W'(to_percent(sv));
        res.cosine_hundredths = HUN_W'(to_percent(cv));
        return res;
    endfunction

    task automatic add_angle(input logic signed [ANGLE_W-1:0] ang, input bit wait_empty);
        angle_req_t req;
        req.angle      = ang;
        req.wait_empty = wait_empty;
        angle_reqs.push_back(req);
    endtask

    task automatic check_field(input string what, input logic signed [RAW_W-1:0] want,
                               input logic signed [RAW_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Stimulus: directed corners, then random angles with two drain points
    initial
    begin
        int pick;
        int k;
        foreach (DIRECTED[i])
            add_angle(DIRECTED[i], 0);
        for (int n = 0; n < RANDOM_ANGLES; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                add_angle($urandom, n == 200 || n == 550);
            else if (pick < 60)
                add_angle($urandom_range(0, 2160 * 65536) - 1080 * 65536, n == 200 || n == 550);
            else if (pick < 85)
            begin
                k = $urandom_range(0, 24) - 12;
                add_angle(k * 90 * 65536 + $urandom_range(0, 64) - 32, n == 200 || n == 550);
            end
            else if (pick < 93)
                add_angle(32'h7FFF_0000 | $urandom_range(0, 65535), n == 200 || n == 550);
            else
                add_angle(32'h8000_0000 | $urandom_range(0, 65535), n == 200 || n == 550);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (angle_reqs.size() != 0 || angle_valid || checked_cnt != accepted_cnt)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (trig_pending.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, trig_pending.size());
        end
        if (errors == 0)
            $display("PASS cordic_sine_cosine_degrees");
        else
            $display("FAIL cordic_sine_cosine_degrees");
        $finish;
    end

    // Angle driver: bursts with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        bit         take_now;
        bit         result_now;
        bit         valid_next;
        angle_req_t req;
        if (!rst_n)
        begin
            angle_valid <= 1'b0;
            angle_deg   <= '0;
        end
        else
        begin
            take_now   = angle_valid && !angle_stall;
            result_now = result_valid && !result_stall && checked_cnt < accepted_cnt;
            if (take_now)
            begin
                trig_pending.push_back(sincos_of_angle(angle_deg));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!(angle_valid && angle_stall))
            begin
                valid_next = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (angle_reqs.size() != 0 && !(angle_reqs[0].wait_empty &&
                         accepted_cnt + take_now != checked_cnt + result_now))
                begin
                    req = angle_reqs.pop_front();
                    angle_deg  <= req.angle;
                    valid_next = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // one burst in four runs long with no gap behind it
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(40, 80);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(0, 15);
                            gap_left   = $urandom_range(1, 8);
                        end
                    end
                end
                angle_valid <= valid_next;
            end
        end
    end

    // Result stall pattern, with one long hold to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        bit stall_next;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            stall_next = 1'b0;
            pattern_cnt++;
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!hold_done && checked_cnt >= HOLD_AT)
            begin
                hold_done  = 1;
                hold_left  = LONG_HOLD - 1;
                stall_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:     stall_next = 1'b0;
                    STALL_LIGHT:    stall_next = ($urandom_range(0, 99) < 30);
                    STALL_HEAVY:    stall_next = ($urandom_range(0, 99) < 75);
                    STALL_PERIODIC: stall_next = ((pattern_cnt % 5) < 2);
                    default:        stall_next = 1'b0;
                endcase
            end
            result_stall <= stall_next;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        trig_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (checked_cnt >= accepted_cnt)
            begin
                errors++;
                $display("%0t: result with no request pending, sine %0d cosine %0d",
                         $time, sine_raw, cosine_raw);
            end
            else
            begin
                want = trig_pending.pop_front();
                check_field("sine_raw", want.sine_raw, sine_raw);
                check_field("cosine_raw", want.cosine_raw, cosine_raw);
                check_field("sine_hundredths", want.sine_hundredths, sine_hundredths);
                check_field("cosine_hundredths", want.cosine_hundredths, cosine_hundredths);
                checked_cnt <= checked_cnt + 1;
            end
        end
    end

    // Watchdog: too long without any request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((angle_valid && !angle_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("FAIL cordic_sine_cosine_degrees");
                $finish;
            end
        end
    end

endmodule

/* cordic_sine_cosine_degrees.f */
hw/rtl/csd_pkg.sv
hw/rtl/csd_mod_cell.sv
hw/rtl/csd_rot_cell.sv
hw/rtl/csd_scale_unit.sv
hw/rtl/cordic_sine_cosine_degrees.sv
sim/cordic_sine_cosine_degrees_tb.sv
